@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/hxb_pkg.sv @@
`default_nettype none

package hxb_pkg;

  localparam int CHAR_W  = 8;
  localparam int CAP_W   = 9;
  localparam int INDEX_W = 8;
  localparam int ERR_W   = 2;
  localparam int NIB_W   = 4;

  localparam int MAX_BYTES = 256;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd32;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ODD      = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF_HI = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic             is_hex;
    logic             is_sep;
    logic [NIB_W-1:0] nib;
  } cls_t;

  typedef struct packed {
    logic               byte_valid;
    logic [CHAR_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               done_res;
    logic [CAP_W-1:0]   byte_count;
    logic [ERR_W-1:0]   error_code;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/hxb_in_if.sv @@
`default_nettype none

interface hxb_in_if import hxb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_end;

  modport source(output valid, character, is_end, input ready);
  modport sink(input valid, character, is_end, output ready);
endinterface

`default_nettype wire

@@ rtl/hxb_out_if.sv @@
`default_nettype none

interface hxb_out_if import hxb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               byte_valid;
  logic [CHAR_W-1:0]  data_byte;
  logic [INDEX_W-1:0] byte_index;
  logic               done_res;
  logic [CAP_W-1:0]   byte_count;
  logic [ERR_W-1:0]   error_code;

  modport source(output valid, byte_valid, data_byte, byte_index, done_res, byte_count,
                 error_code, input ready);
  modport sink(input valid, byte_valid, data_byte, byte_index, done_res, byte_count,
               error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/hxb_char_class.sv @@
`default_nettype none

module hxb_char_class import hxb_pkg::*; (
  input  wire logic [CHAR_W-1:0] ch,
  output cls_t                   cls
);

  always_comb begin
    cls = '0;
    case (ch) inside
      CH_SPACE, CH_TAB, CH_COLON, CH_DASH, CH_COMMA, CH_CR, CH_LF: begin
        cls.is_sep = 1'b1;
      end
      [CH_0:CH_9]: begin
        cls.is_hex = 1'b1;
        cls.nib    = NIB_W'(ch - CH_0);
      end
      [CH_LA:CH_LF_HI]: begin
        cls.is_hex = 1'b1;
        cls.nib    = NIB_W'(ch - CH_LA + HEX_TEN);
      end
      [CH_UA:CH_UF]: begin
        cls.is_hex = 1'b1;
        cls.nib    = NIB_W'(ch - CH_UA + HEX_TEN);
      end
      default: begin
        cls = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/hex_text_to_bytes_parser.sv @@
// Hex text to bytes parser.
// in_ch: one request per character (character, is_end), valid/ready.
// out_ch: one request per decoded byte (byte_valid, data_byte, byte_index)
//   and one per end marker (done_res, byte_count, error_code).
// cfg_we/cfg_wdata: capacity register, written while the block is idle;
// the user keeps to this, as the block does not enforce it. Separators
// produce no result; after an error, characters are dropped until the
// end marker, which reports and clears the string state. Input accept to
// result valid: classify register, then state update and result register.
// Throughput: one character per cycle unless the output stalls; the nibble
// pairing and byte count update in the second stage is the only loop.
// Reset: capacity returns to 32, string state and both valid flags clear.
// Stall: a pending result holds in the output register; one more character
// is taken into the classify register, then in_ch.ready drops until
// out_ch.ready returns.
`default_nettype none
`include "assert_macros.svh"

module hex_text_to_bytes_parser import hxb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  hxb_in_if.sink                in_ch,
  hxb_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam logic [CAP_W-1:0] MAX_LIMIT = CAP_W'(MAX_BYTES);

  logic [CAP_W-1:0] cap_r;

  logic             s1_valid_r;
  logic             s1_end_r;
  cls_t             s1_cls_r;
  cls_t             cls;

  logic [NIB_W-1:0] held_r, held_nxt;
  logic             pend_r, pend_nxt;
  logic [CAP_W-1:0] bytes_r, bytes_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic             res_load;

  logic             s1_fire;
  logic             in_fire;
  logic [CAP_W-1:0] limit;
  logic [ERR_W-1:0] end_err;

  hxb_char_class u_class (
    .ch  (in_ch.character),
    .cls (cls)
  );

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign limit       = (cap_r < MAX_LIMIT) ? cap_r : MAX_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_end_r <= in_ch.is_end;
      s1_cls_r <= cls;
    end
  end

  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    bytes_nxt = bytes_r;
    err_nxt = err_r;
    res_nxt = '0;
    res_load = 1'b0;
    end_err = (err_r == ERR_NONE && pend_r) ? ERR_ODD : err_r;
    if (s1_fire) begin
      if (s1_end_r) begin
        res_load = 1'b1;
        res_nxt.done_res = 1'b1;
        res_nxt.error_code = end_err;
        res_nxt.byte_count = (end_err == ERR_NONE) ? bytes_r : '0;
        held_nxt = '0;
        pend_nxt = 1'b0;
        bytes_nxt = '0;
        err_nxt = ERR_NONE;
      end else if (err_r != ERR_NONE || s1_cls_r.is_sep) begin
        err_nxt = err_r;
      end else if (!s1_cls_r.is_hex) begin
        err_nxt = ERR_BAD_CHAR;
      end else if (!pend_r) begin
        held_nxt = s1_cls_r.nib;
        pend_nxt = 1'b1;
      end else if (bytes_r >= limit) begin
        err_nxt = ERR_OVERFLOW;
      end else begin
        res_load = 1'b1;
        res_nxt.byte_valid = 1'b1;
        res_nxt.data_byte = {held_r, s1_cls_r.nib};
        res_nxt.byte_index = bytes_r[INDEX_W-1:0];
        bytes_nxt = bytes_r + 1'b1;
        held_nxt = '0;
        pend_nxt = 1'b0;
      end
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
      bytes_r <= '0;
      err_r <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
      bytes_r <= bytes_nxt;
      err_r <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_valid = res_r.byte_valid;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.byte_index = res_r.byte_index;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.byte_count = res_r.byte_count;
  assign out_ch.error_code = res_r.error_code;

  // end marker leaves a clean string state
  `ASSERT_CLK(a_end_clears, clk, rst_n,
    s1_fire && s1_end_r |=> bytes_r == '0 && !pend_r && err_r == ERR_NONE)

  // no bytes counted once an error is latched
  `ASSERT_CLK(a_err_freezes_count, clk, rst_n,
    s1_fire && !s1_end_r && err_r != ERR_NONE |=> $stable(bytes_r))

  // a held byte result matches the running count
  `ASSERT_CLK(a_index_tracks_count, clk, rst_n,
    out_valid_r && res_r.byte_valid |-> bytes_r == {1'b0, res_r.byte_index} + 9'd1)

endmodule

`default_nettype wire
